>>> hw/rtl/rfpw_pkg.sv
package rfpw_pkg;

    localparam int FRAME_BITS_DEFAULT = 24;
    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int GAP_W  = 16;
    localparam int CODE_W = 24;
    localparam int IDX_W  = 3;

    localparam logic [GAP_W-1:0]  MIN_GAP_RST  = 16'd5000;
    localparam logic [GAP_W-1:0]  MAX_GAP_RST  = 16'd6200;
    localparam logic [GAP_W-1:0]  ONE_MIN_RST  = 16'd120;
    localparam logic [GAP_W-1:0]  ZERO_MIN_RST = 16'd500;
    localparam logic [CODE_W-1:0] ON_CODE_RST  = {8'h44, 8'h15, 8'h33};
    localparam logic [CODE_W-1:0] OFF_CODE_RST = {8'h44, 8'h15, 8'h3C};

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_GAP  = 3'd0,
        CFG_MAX_GAP  = 3'd1,
        CFG_ONE_MIN  = 3'd2,
        CFG_ZERO_MIN = 3'd3,
        CFG_ON_CODE  = 3'd4,
        CFG_OFF_CODE = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CLS_NONE = 3'd0,
        CLS_SYNC = 3'd1,
        CLS_ZERO = 3'd2,
        CLS_ONE  = 3'd3,
        CLS_BAD  = 3'd4,
        CLS_LONG = 3'd5
    } pulse_class_t;

    typedef struct packed {
        logic [GAP_W-1:0]  min_gap;
        logic [GAP_W-1:0]  max_gap;
        logic [GAP_W-1:0]  one_min;
        logic [GAP_W-1:0]  zero_min;
        logic [CODE_W-1:0] on_code;
        logic [CODE_W-1:0] off_code;
    } cfg_t;

    typedef struct packed {
        logic              lamp_on;
        logic              frame_done;
        logic [CODE_W-1:0] frame_code;
        pulse_class_t      pulse_class;
    } result_t;

endpackage

>>> hw/rtl/rfpw_cfg_regs.sv
module rfpw_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rfpw_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rfpw_pkg::CODE_W-1:0]   cfg_data,
    output rfpw_pkg::cfg_t                cfg
);
    import rfpw_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MIN_GAP:  cfg_next.min_gap  = cfg_data[GAP_W-1:0];
                CFG_MAX_GAP:  cfg_next.max_gap  = cfg_data[GAP_W-1:0];
                CFG_ONE_MIN:  cfg_next.one_min  = cfg_data[GAP_W-1:0];
                CFG_ZERO_MIN: cfg_next.zero_min = cfg_data[GAP_W-1:0];
                CFG_ON_CODE:  cfg_next.on_code  = cfg_data;
                CFG_OFF_CODE: cfg_next.off_code = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_gap  <= MIN_GAP_RST;
            cfg_reg.max_gap  <= MAX_GAP_RST;
            cfg_reg.one_min  <= ONE_MIN_RST;
            cfg_reg.zero_min <= ZERO_MIN_RST;
            cfg_reg.on_code  <= ON_CODE_RST;
            cfg_reg.off_code <= OFF_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/rfpw_decoder.sv
module rfpw_decoder #(
    parameter int FRAME_BITS = rfpw_pkg::FRAME_BITS_DEFAULT,
    parameter int TIMER_BITS = rfpw_pkg::TIMER_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin,
    input  rfpw_pkg::cfg_t    cfg,
    output rfpw_pkg::result_t result
);
    import rfpw_pkg::*;

    localparam int BITS_W = $clog2(FRAME_BITS + 1);
    localparam int CMP_W  = (TIMER_BITS > GAP_W) ? TIMER_BITS : GAP_W;

    logic                  last_level_reg, last_level_next;
    logic                  low_timing_reg, low_timing_next;
    logic [TIMER_BITS-1:0] low_ticks_reg,  low_ticks_next;
    logic                  in_frame_reg,   in_frame_next;
    logic [BITS_W-1:0]     bits_seen_reg,  bits_seen_next;
    logic [FRAME_BITS-1:0] shift_reg,      shift_next;
    logic                  lamp_reg,       lamp_next;

    logic [CMP_W-1:0] width;
    logic             done;
    pulse_class_t     cls;

    assign width = CMP_W'(low_ticks_reg);

    always_comb
    begin
        last_level_next = pin;
        low_timing_next = low_timing_reg;
        low_ticks_next  = low_ticks_reg;
        in_frame_next   = in_frame_reg;
        bits_seen_next  = bits_seen_reg;
        shift_next      = shift_reg;
        lamp_next       = lamp_reg;
        done            = 1'b0;
        cls             = CLS_NONE;

        if (!pin)
        begin
            if (last_level_reg)
            begin
                low_timing_next = 1'b1;
                low_ticks_next  = TIMER_BITS'(1);
            end
            else if (low_timing_reg && (low_ticks_reg != '1))
            begin
                low_ticks_next = low_ticks_reg + 1'b1;
            end
        end
        else if (!last_level_reg && low_timing_reg)
        begin
            // rising edge closes the timed low phase
            low_timing_next = 1'b0;
            low_ticks_next  = '0;
            if (width >= CMP_W'(cfg.max_gap))
            begin
                in_frame_next = 1'b0;
                cls           = CLS_LONG;
            end
            else if (in_frame_reg)
            begin
                if (width > CMP_W'(cfg.zero_min) || width > CMP_W'(cfg.one_min))
                begin
                    cls            = (width > CMP_W'(cfg.zero_min)) ? CLS_ZERO : CLS_ONE;
                    shift_next     = {shift_reg[FRAME_BITS-2:0], (cls == CLS_ONE)};
                    bits_seen_next = bits_seen_reg + 1'b1;
                    if (bits_seen_next >= BITS_W'(FRAME_BITS))
                    begin
                        if (shift_next == FRAME_BITS'(cfg.on_code))
                            lamp_next = 1'b1;
                        else if (shift_next == FRAME_BITS'(cfg.off_code))
                            lamp_next = 1'b0;
                        in_frame_next = 1'b0;
                        done          = 1'b1;
                    end
                end
                else
                begin
                    in_frame_next = 1'b0;
                    cls           = CLS_BAD;
                end
            end
            else if (width > CMP_W'(cfg.min_gap))
            begin
                in_frame_next  = 1'b1;
                bits_seen_next = '0;
                shift_next     = '0;
                cls            = CLS_SYNC;
            end
        end
    end

    always_comb
    begin
        result.lamp_on     = lamp_next;
        result.frame_done  = done;
        result.frame_code  = done ? CODE_W'(shift_next) : '0;
        result.pulse_class = cls;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg <= 1'b1;
            low_timing_reg <= 1'b0;
            low_ticks_reg  <= '0;
            in_frame_reg   <= 1'b0;
            bits_seen_reg  <= '0;
            shift_reg      <= '0;
            lamp_reg       <= 1'b0;
        end
        else if (step)
        begin
            last_level_reg <= last_level_next;
            low_timing_reg <= low_timing_next;
            low_ticks_reg  <= low_ticks_next;
            in_frame_reg   <= in_frame_next;
            bits_seen_reg  <= bits_seen_next;
            shift_reg      <= shift_next;
            lamp_reg       <= lamp_next;
        end
    end

endmodule

>>> hw/rtl/rf_pulse_width_code_receiver.sv
// Pulse-width code receiver: one pin sample per timing tick goes in on the
// in channel and exactly one result comes out on the out channel for each
// sample, in order. The block takes one sample every clock cycle while no
// result is held on the out channel; the figure is set by the decoder step
// between the sample register and the result register that it loads.
// The result register and the sample register decouple the two sides, so a
// waiting result still lets one more sample in. Threshold and code registers
// are written through the cfg channel (always ready) and act at once; write
// them only while no sample is in flight. FRAME_BITS sets the code length and
// TIMER_BITS the saturating low-phase timer.
module rf_pulse_width_code_receiver #(
    parameter int FRAME_BITS = rfpw_pkg::FRAME_BITS_DEFAULT,
    parameter int TIMER_BITS = rfpw_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rfpw_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rfpw_pkg::CODE_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        pin_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        lamp_on,
    output logic                        frame_done,
    output logic [rfpw_pkg::CODE_W-1:0] frame_code,
    output logic [2:0]                  pulse_class
);
    import rfpw_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t result_reg;

    logic in_valid_reg, in_valid_next;
    logic pin_reg;
    logic out_valid_reg, out_valid_next;
    logic advance;

    rfpw_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfpw_decoder #(
        .FRAME_BITS (FRAME_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (in_valid_reg && advance),
        .pin    (pin_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            pin_reg <= pin_level;
        if (in_valid_reg && advance)
            result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign lamp_on     = result_reg.lamp_on;
    assign frame_done  = result_reg.frame_done;
    assign frame_code  = result_reg.frame_code;
    assign pulse_class = result_reg.pulse_class;

    // a finished frame is always closed by a data bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (pulse_class == CLS_ZERO || pulse_class == CLS_ONE))
    else $error("frame_done without a data bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_done) |-> (frame_code == '0))
    else $error("frame_code set outside a completed frame");

    // input only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && in_valid_reg))
    else $error("input stalled without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_reg)))
    else $error("held result changed");

endmodule

>>> tb/tb_rf_pulse_width_code_receiver.sv
module tb_rf_pulse_width_code_receiver;
    import rfpw_pkg::*;

    localparam int RAND_ITEMS     = 600;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 150;
    localparam int NOISE_ITEMS    = 60;

    localparam int SEND_IDLE_A = 23;
    localparam int RECV_IDLE_A = 70;
    localparam int SEND_IDLE_B = 70;
    localparam int RECV_IDLE_B = 23;

    typedef enum {ROW_RUN, ROW_PULSE, ROW_CFG, ROW_FRAME} row_kind_t;

    // RUN: val high samples; PULSE: val low samples then one high;
    // CFG: register write; FRAME: sync plus all bits of code val.
    typedef struct {
        row_kind_t    kind;
        cfg_idx_t     idx;
        logic [31:0]  val;
        bit           typed;
        pulse_class_t cls;
    } dir_row_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_valid   = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index   = '0;
    logic [CODE_W-1:0] cfg_data    = '0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic              pin_level   = 1'b1;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic              lamp_on;
    logic              frame_done;
    logic [CODE_W-1:0] frame_code;
    logic [2:0]        pulse_class;

    // receiver model state and its copy of the registers
    cfg_t                          rx_cfg;
    logic                          rx_last;
    logic                          rx_timing;
    logic [TIMER_BITS_DEFAULT-1:0] rx_ticks;
    logic                          rx_in_frame;
    logic [4:0]                    rx_bits;
    logic [CODE_W-1:0]             rx_shift;
    logic                          rx_lamp;

    result_t     tick_results[$];
    dir_row_t    dir_rows[$];
    int          mismatches    = 0;
    int unsigned sent_items    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_ack      = 0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    rf_pulse_width_code_receiver dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pin_level  (pin_level),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .lamp_on    (lamp_on),
        .frame_done (frame_done),
        .frame_code (frame_code),
        .pulse_class(pulse_class)
    );

    always #5 clk = ~clk;

    function automatic result_t decode_tick(input logic pin);
        result_t                       r;
        logic [TIMER_BITS_DEFAULT-1:0] w;
        logic                          b;
        r = '0;
        r.pulse_class = CLS_NONE;
        b = 1'b0;
        if (!pin) begin
            if (rx_last) begin
                rx_timing = 1'b1;
                rx_ticks  = TIMER_BITS_DEFAULT'(1);
            end
            else if (rx_timing && rx_ticks != '1) begin
                rx_ticks = rx_ticks + 1'b1;
            end
        end
        else if (!rx_last && rx_timing) begin
            w = rx_ticks;
            rx_timing = 1'b0;
            rx_ticks  = '0;
            if (w >= rx_cfg.max_gap) begin
                rx_in_frame   = 1'b0;
                r.pulse_class = CLS_LONG;
            end
            else if (rx_in_frame) begin
                if (w > rx_cfg.zero_min) begin
                    b = 1'b0;
                    r.pulse_class = CLS_ZERO;
                end
                else if (w > rx_cfg.one_min) begin
                    b = 1'b1;
                    r.pulse_class = CLS_ONE;
                end
                else begin
                    rx_in_frame   = 1'b0;
                    r.pulse_class = CLS_BAD;
                end
                if (r.pulse_class != CLS_BAD) begin
                    rx_shift = {rx_shift[CODE_W-2:0], b};
                    rx_bits  = rx_bits + 1'b1;
                    if (rx_bits >= FRAME_BITS_DEFAULT) begin
                        if (rx_shift == rx_cfg.on_code)
                            rx_lamp = 1'b1;
                        else if (rx_shift == rx_cfg.off_code)
                            rx_lamp = 1'b0;
                        rx_in_frame  = 1'b0;
                        r.frame_done = 1'b1;
                        r.frame_code = rx_shift;
                    end
                end
            end
            else if (w > rx_cfg.min_gap) begin
                rx_in_frame   = 1'b1;
                rx_bits       = '0;
                rx_shift      = '0;
                r.pulse_class = CLS_SYNC;
            end
        end
        rx_last = pin;
        r.lamp_on = rx_lamp;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    function automatic void add_row(input row_kind_t kind, input cfg_idx_t idx,
                                    input logic [31:0] val, input bit typed,
                                    input pulse_class_t cls);
        dir_row_t row;
        row.kind  = kind;
        row.idx   = idx;
        row.val   = val;
        row.typed = typed;
        row.cls   = cls;
        dir_rows.push_back(row);
    endfunction

    task automatic send_sample(input logic pin, input bit typed, input result_t want);
        bit      acc;
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        pin_level <= pin;
        do begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end while (!acc);
        r = decode_tick(pin);
        tick_results.push_back(typed ? want : r);
        sent_items++;
    endtask

    task automatic send_level(input logic pin);
        send_sample(pin, 1'b0, '0);
    endtask

    // low phase of len ticks, then highs samples; a typed result is for the rising edge
    task automatic send_pulse(input int unsigned len, input int unsigned highs,
                              input bit typed, input result_t want);
        repeat (len) send_level(1'b0);
        send_sample(1'b1, typed, want);
        repeat (highs - 1) send_level(1'b1);
    endtask

    task automatic send_frame(input logic [CODE_W-1:0] code, input int nbits);
        int unsigned len;
        send_pulse($urandom_range(rx_cfg.min_gap + 1, rx_cfg.max_gap - 1),
                   $urandom_range(1, 3), 1'b0, '0);
        for (int i = 0; i < nbits; i++) begin
            if (code[CODE_W-1-i])
                len = $urandom_range(rx_cfg.one_min + 1, rx_cfg.zero_min);
            else
                len = $urandom_range(rx_cfg.zero_min + 1, rx_cfg.max_gap - 1);
            send_pulse(len, $urandom_range(1, 3), 1'b0, '0);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (tick_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CODE_W-1:0] val);
        bit acc;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end while (!acc);
        case (idx)
            CFG_MIN_GAP:  rx_cfg.min_gap  = val[GAP_W-1:0];
            CFG_MAX_GAP:  rx_cfg.max_gap  = val[GAP_W-1:0];
            CFG_ONE_MIN:  rx_cfg.one_min  = val[GAP_W-1:0];
            CFG_ZERO_MIN: rx_cfg.zero_min = val[GAP_W-1:0];
            CFG_ON_CODE:  rx_cfg.on_code  = val;
            CFG_OFF_CODE: rx_cfg.off_code = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // receiver side: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(negedge clk) begin
        result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (tick_results.size() == 0) begin
                report_mismatch("result with nothing pending", pulse_class, 0);
            end
            else begin
                want = tick_results.pop_front();
                if (lamp_on !== want.lamp_on)
                    report_mismatch("lamp_on", lamp_on, want.lamp_on);
                if (frame_done !== want.frame_done)
                    report_mismatch("frame_done", frame_done, want.frame_done);
                if (frame_code !== want.frame_code)
                    report_mismatch("frame_code", frame_code, want.frame_code);
                if (pulse_class !== want.pulse_class)
                    report_mismatch("pulse_class", pulse_class, want.pulse_class);
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        result_t           want;
        int unsigned       rand_start;
        int unsigned       phase_start;
        int unsigned       phase_len;
        int                phase;
        int                one_m, zero_m, min_m, max_m, cap;
        int                sel;
        bit                frames_ok;
        bit                hold_done;
        logic [CODE_W-1:0] code;

        rx_cfg = {MIN_GAP_RST, MAX_GAP_RST, ONE_MIN_RST, ZERO_MIN_RST,
                  ON_CODE_RST, OFF_CODE_RST};
        rx_last     = 1'b1;
        rx_timing   = 1'b0;
        rx_ticks    = '0;
        rx_in_frame = 1'b0;
        rx_bits     = '0;
        rx_shift    = '0;
        rx_lamp     = 1'b0;

        // idle line and a short low ignored under the reset thresholds
        add_row(ROW_RUN,   CFG_MIN_GAP,  3,     1'b1, CLS_NONE);
        add_row(ROW_PULSE, CFG_MIN_GAP,  100,   1'b1, CLS_NONE);
        add_row(ROW_CFG,   CFG_MIN_GAP,  8,     1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_MAX_GAP,  12,    1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_ONE_MIN,  1,     1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_ZERO_MIN, 4,     1'b0, CLS_NONE);
        // long low, sync, one, zero, bad bit
        add_row(ROW_PULSE, CFG_MIN_GAP,  12,    1'b1, CLS_LONG);
        add_row(ROW_PULSE, CFG_MIN_GAP,  9,     1'b1, CLS_SYNC);
        add_row(ROW_PULSE, CFG_MIN_GAP,  4,     1'b0, CLS_NONE);
        add_row(ROW_PULSE, CFG_MIN_GAP,  5,     1'b0, CLS_NONE);
        add_row(ROW_PULSE, CFG_MIN_GAP,  1,     1'b1, CLS_BAD);
        // both codes equal, then off, then a code matching neither
        add_row(ROW_CFG,   CFG_ON_CODE,  24'hA5A5A5, 1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_OFF_CODE, 24'hA5A5A5, 1'b0, CLS_NONE);
        add_row(ROW_FRAME, CFG_MIN_GAP,  24'hA5A5A5, 1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_OFF_CODE, 24'h5A5A5A, 1'b0, CLS_NONE);
        add_row(ROW_FRAME, CFG_MIN_GAP,  24'h5A5A5A, 1'b0, CLS_NONE);
        add_row(ROW_FRAME, CFG_MIN_GAP,  24'h123456, 1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_ON_CODE,  24'hFFFFFF, 1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_OFF_CODE, 24'h000000, 1'b0, CLS_NONE);
        add_row(ROW_FRAME, CFG_MIN_GAP,  24'hFFFFFF, 1'b0, CLS_NONE);
        add_row(ROW_FRAME, CFG_MIN_GAP,  24'h000000, 1'b0, CLS_NONE);
        add_row(ROW_CFG,   CFG_MAX_GAP,  0,     1'b0, CLS_NONE);
        add_row(ROW_PULSE, CFG_MIN_GAP,  1,     1'b1, CLS_LONG);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle(SEND_IDLE_A, RECV_IDLE_A);
        foreach (dir_rows[i]) begin
            want = '0;
            want.pulse_class = dir_rows[i].cls;
            case (dir_rows[i].kind)
                ROW_RUN:
                    for (int j = 0; j < dir_rows[i].val; j++)
                        send_sample(1'b1, dir_rows[i].typed && j == dir_rows[i].val - 1,
                                    want);
                ROW_PULSE:
                    send_pulse(dir_rows[i].val, 1, dir_rows[i].typed, want);
                ROW_CFG: begin
                    drain();
                    write_reg(dir_rows[i].idx, dir_rows[i].val[CODE_W-1:0]);
                end
                ROW_FRAME:
                    send_frame(dir_rows[i].val[CODE_W-1:0], FRAME_BITS_DEFAULT);
                default: ;
            endcase
        end

        rand_start = sent_items;
        phase      = 0;
        hold_done  = 1'b0;
        hold_req   <= hold_req + 1;
        while (sent_items - rand_start < RAND_ITEMS) begin
            drain();
            if (sent_items - rand_start < RAND_ITEMS / 3) begin
                set_idle(SEND_IDLE_A, RECV_IDLE_A);
            end
            else if (sent_items - rand_start < 2 * RAND_ITEMS / 3) begin
                set_idle(SEND_IDLE_B, RECV_IDLE_B);
            end
            else begin
                set_idle(0, 0);
                if (!hold_done) begin
                    hold_req  <= hold_req + 1;
                    hold_done = 1'b1;
                end
            end

            if (phase == 2) begin
                one_m = 0; zero_m = 0; min_m = 0; max_m = 0;
            end
            else if (phase == 6) begin
                one_m = 16'hFFFF; zero_m = 16'hFFFF; min_m = 16'hFFFF; max_m = 16'hFFFF;
            end
            else begin
                one_m  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
                zero_m = one_m + $urandom_range(1, 4);
                max_m  = zero_m + $urandom_range(3, 12);
                min_m  = ($urandom_range(5) == 0) ? 0 : $urandom_range(zero_m, max_m - 2);
            end
            write_reg(CFG_MIN_GAP,  CODE_W'(min_m));
            write_reg(CFG_MAX_GAP,  CODE_W'(max_m));
            write_reg(CFG_ONE_MIN,  CODE_W'(one_m));
            write_reg(CFG_ZERO_MIN, CODE_W'(zero_m));
            code = (phase == 6) ? 24'hFFFFFF : CODE_W'($urandom);
            write_reg(CFG_ON_CODE, code);
            if ($urandom_range(4) != 0)
                code = CODE_W'($urandom);
            write_reg(CFG_OFF_CODE, code);

            frames_ok = (one_m < zero_m) && (zero_m + 1 <= max_m - 1) &&
                        (min_m + 1 <= max_m - 1);
            cap = (max_m + 2 > 40) ? 40 : max_m + 2;
            phase_len = frames_ok ? PHASE_ITEMS : NOISE_ITEMS;
            phase_start = sent_items;
            while (sent_items - phase_start < phase_len) begin
                sel = $urandom_range(99);
                if (!frames_ok || sel < 10) begin
                    repeat ($urandom_range(0, 4)) send_level($urandom_range(1));
                    repeat ($urandom_range(1, 6))
                        send_pulse($urandom_range(1, cap), $urandom_range(1, 4), 1'b0, '0);
                end
                else if (sel < 75) begin
                    case ($urandom_range(3))
                        0:       code = rx_cfg.on_code;
                        1:       code = rx_cfg.off_code;
                        default: code = CODE_W'($urandom);
                    endcase
                    send_frame(code, FRAME_BITS_DEFAULT);
                end
                else if (sel < 87) begin
                    // frame cut short, sometimes ended by a too-long low
                    send_frame(CODE_W'($urandom),
                               $urandom_range(0, FRAME_BITS_DEFAULT - 1));
                    if ($urandom_range(1))
                        send_pulse($urandom_range(max_m, max_m + 5), 1, 1'b0, '0);
                end
                else begin
                    send_frame(CODE_W'($urandom),
                               $urandom_range(0, FRAME_BITS_DEFAULT - 1));
                    if (one_m >= 1)
                        send_pulse($urandom_range(1, one_m), $urandom_range(1, 3),
                                   1'b0, '0);
                    send_frame(CODE_W'($urandom), $urandom_range(0, 5));
                end
            end
            phase++;
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
